### src/rtt_pkg.sv
// package for the repeating timer table
// types, result codes and sizes shared by the slot cell, the chain and the top level
package rtt_pkg;

  localparam int SLOTS = 16;
  localparam int SLOT_W = 4;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_EXISTS = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    RES_FIRE   = 3'd0,
    RES_ADD    = 3'd1,
    RES_REMOVE = 3'd2,
    RES_EXISTS = 3'd3,
    RES_DONE   = 3'd4
  } res_kind_t;

  localparam logic [1:0] REG_MARGIN = 2'd0;

  // one slot's timer as it moves down the chain
  typedef struct packed {
    logic        live;
    logic [31:0] remaining;
    logic [30:0] period;
    logic [31:0] count;
    logic [31:0] owner;
    logic        add_pend;
    logic [30:0] p_period;
    logic [31:0] p_count;
    logic [31:0] p_owner;
    logic        rem_pend;
  } slot_t;

  // fire report from the head cell
  typedef struct packed {
    logic        fire;
    logic        retired;
    logic [31:0] owner;
    logic [30:0] period;
    logic [31:0] count;
  } fire_t;

endpackage

### src/rtt_cell.sv
// one timer cell of the rotating chain; the tick update for the head cell is done in the top level
// depends on rtt_pkg
module rtt_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  logic          load,
  input  rtt_pkg::slot_t load_val,
  input  rtt_pkg::slot_t prev,
  output rtt_pkg::slot_t cur
);
  import rtt_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.live     <= 1'b0;
      cur.add_pend <= 1'b0;
      cur.rem_pend <= 1'b0;
    end else if (load) begin
      cur <= load_val;
    end else if (shift) begin
      cur <= prev;
    end
  end

endmodule

### src/rtt_chain.sv
// ring of slot cells; the head cell sees slot 0 after every full rotation
// depends on rtt_pkg and rtt_cell
module rtt_chain (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift,
  input  logic           wr_en,
  input  logic [rtt_pkg::SLOT_W-1:0] wr_slot,
  input  rtt_pkg::slot_t wr_val,
  input  rtt_pkg::slot_t head_next,
  output rtt_pkg::slot_t head,
  output rtt_pkg::slot_t cells [rtt_pkg::SLOTS]
);
  import rtt_pkg::*;

  // head is cell 0; on a shift cell i takes cell i+1 and the tail takes the update
  // when idle every cell sits at its own slot and can be written directly
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    rtt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (shift),
      .load     ((shift && (i == SLOTS - 1)) || (wr_en && (wr_slot == SLOT_W'(i)))),
      .load_val (shift ? head_next : wr_val),
      .prev     (cells[(i + 1) % SLOTS]),
      .cur      (cells[i])
    );
  end

  assign head = cells[0];

endmodule

### src/repeating_timer_table_top.sv
// repeating timer table top level: request decode, tick sequencer, apb register
// depends on rtt_pkg and rtt_chain
//
// add, remove and exists return one word the cycle after start; busy stays
// low for them. a tick holds busy while the ring of slot cells rotates once
// through the head cell, one slot a cycle, and then while the done word is
// registered. each fire word shows the cycle after its slot passes the head,
// and the done word shows in the same cycle that busy falls, so a tick gives
// up to sixteen fire words then a done word. results cannot be stalled.
module repeating_timer_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [3:0]  slot,
  input  logic [30:0] elapsed_us,
  input  logic [30:0] period_us,
  input  logic signed [31:0] repeat_count,
  input  logic [31:0] owner_id,
  output logic        res_valid,
  output logic [2:0]  res_kind,
  output logic [3:0]  res_slot,
  output logic [31:0] res_owner,
  output logic [30:0] res_period,
  output logic signed [31:0] res_count,
  output logic        retired,
  output logic        found,
  output logic        last_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rtt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_TICK = 2'b10
  } state_t;

  state_t       state;
  logic [19:0]  margin;
  logic [30:0]  elapsed;
  logic [SLOT_W:0] step;
  slot_t        head, head_next;
  slot_t        cells [SLOTS];
  fire_t        fr;
  logic         shift, accept;
  logic [SLOT_W-1:0] head_slot;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_MARGIN) ? {12'd0, margin} : 32'd0;
  assign busy   = (state == ST_TICK);
  assign accept = start && !busy;
  // the ring rotates only while slots are still being visited
  assign shift  = (state == ST_TICK) && !step[SLOT_W];
  assign head_slot = step[SLOT_W-1:0];

  // add (unless one is already pending) and remove write the addressed cell directly when idle; exists only reads it
  logic          direct_we;
  slot_t         direct_val;

  rtt_chain u_chain (
    .clk       (clk),
    .rst       (rst),
    .shift     (shift),
    .wr_en     (direct_we),
    .wr_slot   (slot),
    .wr_val    (direct_val),
    .head_next (head_next),
    .head      (head),
    .cells     (cells)
  );

  // head update: tick, then remove, then add
  always_comb begin
    logic signed [33:0] rem;
    logic signed [33:0] cnt;
    slot_t n;
    rem = 34'(signed'(head.remaining));
    cnt = 34'(signed'(head.count));
    n   = head;
    fr  = '0;
    fr.owner  = head.owner;
    fr.period = head.period;
    if (head.live) begin
      if (rem > 0) rem = rem - signed'(34'(elapsed));
      if (rem <= signed'(34'(margin))) cnt = cnt - 34'sd1;
      else n.remaining = rem[31:0];
      if (cnt <= 0) begin
        fr.fire = 1'b1; fr.retired = 1'b1; fr.count = head.count;
        n.live = 1'b0;
      end else if (cnt != 34'(signed'(head.count))) begin
        fr.fire = 1'b1; fr.count = cnt[31:0];
        n.count = cnt[31:0];
        n.remaining = {1'b0, head.period};
      end
    end
    if (n.rem_pend) n.live = 1'b0;
    n.rem_pend = 1'b0;
    if (n.add_pend && !n.live) begin
      n.live = 1'b1;
      n.remaining = {1'b0, n.p_period};
      n.period = n.p_period;
      n.count = n.p_count;
      n.owner = n.p_owner;
    end
    n.add_pend = 1'b0;
    head_next = n;
  end

  always_comb begin
    direct_val = cells[slot];
    direct_we  = 1'b0;
    if (accept && req_type == REQ_ADD && !direct_val.add_pend) begin
      direct_we = 1'b1;
      direct_val.add_pend = 1'b1;
      direct_val.p_period = period_us;
      direct_val.p_count  = repeat_count;
      direct_val.p_owner  = owner_id;
    end else if (accept && req_type == REQ_REMOVE) begin
      direct_we = 1'b1;
      direct_val.rem_pend = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      margin    <= 20'd1000;
      res_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (psel && penable && pwrite && paddr == REG_MARGIN) margin <= pwdata[19:0];
      unique case (state)
        ST_IDLE: begin
          res_valid <= accept && (req_type != REQ_TICK);
          if (accept) begin
            if (req_type == REQ_TICK) begin
              state   <= ST_TICK;
              step    <= '0;
              elapsed <= elapsed_us;
            end else begin
              res_kind   <= (req_type == REQ_ADD) ? RES_ADD :
                            (req_type == REQ_REMOVE) ? RES_REMOVE : RES_EXISTS;
              res_slot   <= slot;
              res_owner  <= '0;
              res_period <= '0;
              res_count  <= '0;
              retired    <= 1'b0;
              found      <= (req_type == REQ_EXISTS) && cells[slot].live;
              last_item  <= 1'b1;
            end
          end
        end
        ST_TICK: begin
          if (step[SLOT_W]) begin
            // every slot visited: done word closes the tick
            res_valid  <= 1'b1;
            res_kind   <= RES_DONE;
            res_slot   <= '0;
            res_owner  <= '0;
            res_period <= '0;
            res_count  <= '0;
            retired    <= 1'b0;
            found      <= 1'b0;
            last_item  <= 1'b1;
            state      <= ST_IDLE;
          end else begin
            step <= step + 1'b1;
            res_slot   <= head_slot;
            res_owner  <= fr.owner;
            res_period <= fr.period;
            res_count  <= fr.count;
            retired    <= fr.retired;
            found      <= 1'b0;
            res_kind   <= RES_FIRE;
            last_item  <= 1'b0;
            res_valid  <= fr.fire;
          end
        end
        default: begin
          res_valid <= 1'b0;
          state     <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
